// ===== rtl/ttc_eb_pkg.sv =====
// ----------------------------------------------------------------------------
// Time-to-collision emergency brake: shared package
// Register indexes, state memory layout and the cosine table constants.
// ----------------------------------------------------------------------------
`default_nettype none

package ttc_eb_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_TTC_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_START   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP    = 3'd4;

  localparam logic [15:0] TTC_THRESHOLD_RST = 16'd500;
  localparam logic [15:0] RANGE_MIN_RST     = 16'd0;
  localparam logic [15:0] RANGE_MAX_RST     = 16'd65535;
  localparam logic [15:0] ANGLE_START_RST   = 16'hA000;
  localparam logic [9:0]  ANGLE_STEP_RST    = 10'd46;

  // The state memory holds the speed in one entry and the scan state in the other.
  localparam int unsigned STATE_DEPTH = 2;
  localparam int unsigned WORD_W      = 17;
  localparam logic ENTRY_SPEED = 1'b0;
  localparam logic ENTRY_SCAN  = 1'b1;

  typedef struct packed {
    logic        brake;
    logic [15:0] angle;
  } scan_word_t;

  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

endpackage

`default_nettype wire

// ===== rtl/ttc_eb_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ttc_eb_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/ttc_emergency_brake_core.sv =====
// ----------------------------------------------------------------------------
// Time-to-collision emergency brake core
// Tracks forward speed and lidar beams and latches a brake request when the
// projected time to collision of a valid beam falls below the threshold.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_*       in         tuser: func, tlast: last_beam, tdata: speed, range
//  m_*       out        tdata: brake, drive speed
//  cfg_*     in         register index and write data
//
// A speed request is written straight into the state memory; a beam request
// runs RD, MUL1, MUL2, WB for the two state memory reads and chained products.
// After reset INIT0 and INIT1 write the state memory; no request is taken.
// A last beam waits in write-back while the output register still holds a
// result that has not been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ttc_emergency_brake_core #(
  parameter int unsigned COS_TABLE_BITS = 12
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [15:0] speed_mm_s, [31:16] range_mm
  input  wire logic        s_tuser,   // [0] func
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [23:0] m_tdata,   // [0] brake, [16:1] drive_speed_mm_s
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int unsigned QUARTER_BITS = COS_TABLE_BITS - 2;
  localparam int unsigned QUARTER      = 1 << QUARTER_BITS;
  localparam int unsigned ROM_IDX_W    = COS_TABLE_BITS - 1;
  localparam logic [ROM_IDX_W-1:0] QUARTER_IDX = ROM_IDX_W'(QUARTER);

  localparam logic [2:0] S_INIT0 = 3'd0;
  localparam logic [2:0] S_INIT1 = 3'd1;
  localparam logic [2:0] S_IDLE  = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_MUL1  = 3'd4;
  localparam logic [2:0] S_MUL2  = 3'd5;
  localparam logic [2:0] S_WB    = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  logic [15:0] ttc_threshold_ms;
  logic [15:0] range_min_mm;
  logic [15:0] range_max_mm;
  logic [15:0] angle_start;
  logic [9:0]  angle_step;

  logic        last;
  logic        in_range;
  logic [25:0] lhs_base;
  logic        latch;
  logic [15:0] angle;
  logic [15:0] cmag;
  logic        cneg;
  logic [15:0] speed;
  logic        sneg;
  logic [31:0] prod1;
  logic [47:0] prod2;

  logic        out_brake;
  logic [15:0] out_speed;

  logic                   ram_we;
  logic                   ram_waddr;
  logic [ttc_eb_pkg::WORD_W-1:0] ram_wdata;
  logic                   ram_raddr;
  logic [ttc_eb_pkg::WORD_W-1:0] ram_rdata;

  ttc_eb_pkg::scan_word_t scan_rd;
  ttc_eb_pkg::scan_word_t scan_wr;

  logic        scan_fwd;
  logic        scan_fwd_brake;
  logic        cur_brake;

  logic        cfg_angle_wr;
  logic [15:0] angle_start_cur;
  logic        accept;
  logic        out_free;
  logic        wb_fire;
  logic        hit;
  logic        brake_new;
  logic [15:0] angle_new;
  logic [15:0] in_speed;
  logic [15:0] in_range_mm;
  logic [25:0] range_x1000;
  logic [COS_TABLE_BITS-1:0] cos_idx;
  logic [QUARTER_BITS-1:0]   cos_r;
  logic [1:0]                cos_quad;
  logic [ROM_IDX_W-1:0]      rom_idx;
  logic [15:0] smag;

  logic [15:0] cos_rom [QUARTER+1];

  // Each entry evaluates the Horner series in Q30 and rounds it to Q15.
  for (genvar q = 0; q <= QUARTER; q++) begin : g_cos
    localparam logic [63:0] X  = (ttc_eb_pkg::HALF_PI_Q30 * 64'(q)) >> QUARTER_BITS;
    localparam logic [63:0] X2 = (X * X) >> 30;
    localparam logic [63:0] S0 = (X2 * ttc_eb_pkg::ONE_Q30) / (64'd90 << 30);
    localparam logic [63:0] T0 = (S0 >= ttc_eb_pkg::ONE_Q30) ? 64'd0
                               : ttc_eb_pkg::ONE_Q30 - S0;
    localparam logic [63:0] S1 = (X2 * T0) / (64'd56 << 30);
    localparam logic [63:0] T1 = (S1 >= ttc_eb_pkg::ONE_Q30) ? 64'd0
                               : ttc_eb_pkg::ONE_Q30 - S1;
    localparam logic [63:0] S2 = (X2 * T1) / (64'd30 << 30);
    localparam logic [63:0] T2 = (S2 >= ttc_eb_pkg::ONE_Q30) ? 64'd0
                               : ttc_eb_pkg::ONE_Q30 - S2;
    localparam logic [63:0] S3 = (X2 * T2) / (64'd12 << 30);
    localparam logic [63:0] T3 = (S3 >= ttc_eb_pkg::ONE_Q30) ? 64'd0
                               : ttc_eb_pkg::ONE_Q30 - S3;
    localparam logic [63:0] S4 = (X2 * T3) / (64'd2 << 30);
    localparam logic [63:0] T4 = (S4 >= ttc_eb_pkg::ONE_Q30) ? 64'd0
                               : ttc_eb_pkg::ONE_Q30 - S4;
    localparam logic [63:0] C  = (T4 + (64'd1 << 14)) >> 15;
    localparam logic [15:0] COS_VAL = (C > 64'd32768) ? 16'h8000 : C[15:0];
    assign cos_rom[q] = COS_VAL;
  end

  ttc_eb_ram #(
    .WIDTH (ttc_eb_pkg::WORD_W),
    .DEPTH (ttc_eb_pkg::STATE_DEPTH)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cfg_angle_wr    = cfg_we && (cfg_index == ttc_eb_pkg::REG_ANGLE_START);
  assign angle_start_cur = cfg_angle_wr ? cfg_data : angle_start;
  assign s_tready        = (state == S_IDLE) && !cfg_angle_wr;
  assign accept          = s_tvalid && s_tready;
  assign out_free        = !m_tvalid || m_tready;
  assign wb_fire         = (state == S_WB) && (!last || out_free);

  assign in_speed    = s_tdata[15:0];
  assign in_range_mm = s_tdata[31:16];
  assign range_x1000 = ({10'd0, in_range_mm} << 10) - ({10'd0, in_range_mm} << 4)
                     - ({10'd0, in_range_mm} << 3);

  assign scan_rd  = ttc_eb_pkg::scan_word_t'(ram_rdata);
  assign cos_idx  = scan_rd.angle[15 -: COS_TABLE_BITS];
  assign cos_quad = cos_idx[COS_TABLE_BITS-1 -: 2];
  assign cos_r    = cos_idx[QUARTER_BITS-1:0];
  assign rom_idx  = cos_quad[0] ? (QUARTER_IDX - {1'b0, cos_r}) : {1'b0, cos_r};

  // The scan entry read while idle misses a write made at the same edge.
  assign cur_brake = scan_fwd ? scan_fwd_brake : scan_rd.brake;

  assign smag = ram_rdata[15] ? (~ram_rdata[15:0] + 16'd1) : ram_rdata[15:0];

  assign hit = !latch && in_range && (speed != 16'd0) && (cmag != 16'd0)
            && (sneg == cneg) && ({7'd0, lhs_base, 15'd0} < prod2);
  assign brake_new = latch || hit;
  assign angle_new = angle + {6'd0, angle_step};

  always_comb begin
    scan_wr   = '0;
    ram_we    = 1'b0;
    ram_waddr = ttc_eb_pkg::ENTRY_SCAN;
    ram_wdata = '0;
    ram_raddr = (state == S_RD) ? ttc_eb_pkg::ENTRY_SPEED : ttc_eb_pkg::ENTRY_SCAN;
    unique case (state)
      S_INIT0: begin
        ram_we    = 1'b1;
        ram_waddr = ttc_eb_pkg::ENTRY_SPEED;
      end
      S_INIT1: begin
        scan_wr.angle = angle_start_cur;
        ram_we        = 1'b1;
        ram_wdata     = scan_wr;
      end
      S_IDLE: begin
        if (accept && !s_tuser) begin
          ram_we    = 1'b1;
          ram_waddr = ttc_eb_pkg::ENTRY_SPEED;
          ram_wdata = {1'b0, in_speed};
        end else if (cfg_angle_wr) begin
          scan_wr.brake = cur_brake;
          scan_wr.angle = cfg_data;
          ram_we        = 1'b1;
          ram_wdata     = scan_wr;
        end
      end
      S_WB: begin
        if (last) begin
          scan_wr.angle = angle_start;
        end else begin
          scan_wr.brake = brake_new;
          scan_wr.angle = angle_new;
        end
        ram_we    = wb_fire;
        ram_wdata = scan_wr;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT0: state_next = S_INIT1;
      S_INIT1: state_next = S_IDLE;
      S_IDLE: begin
        if (accept && s_tuser) begin
          state_next = S_RD;
        end
      end
      S_RD:   state_next = S_MUL1;
      S_MUL1: state_next = S_MUL2;
      S_MUL2: state_next = S_WB;
      S_WB: begin
        if (wb_fire) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_INIT0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT0;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ttc_threshold_ms <= ttc_eb_pkg::TTC_THRESHOLD_RST;
      range_min_mm     <= ttc_eb_pkg::RANGE_MIN_RST;
      range_max_mm     <= ttc_eb_pkg::RANGE_MAX_RST;
      angle_start      <= ttc_eb_pkg::ANGLE_START_RST;
      angle_step       <= ttc_eb_pkg::ANGLE_STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ttc_eb_pkg::REG_TTC_THRESHOLD: ttc_threshold_ms <= cfg_data;
        ttc_eb_pkg::REG_RANGE_MIN:     range_min_mm     <= cfg_data;
        ttc_eb_pkg::REG_RANGE_MAX:     range_max_mm     <= cfg_data;
        ttc_eb_pkg::REG_ANGLE_START:   angle_start      <= cfg_data;
        ttc_eb_pkg::REG_ANGLE_STEP:    angle_step       <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    scan_fwd       <= ram_we && (ram_waddr == ttc_eb_pkg::ENTRY_SCAN);
    scan_fwd_brake <= ram_wdata[ttc_eb_pkg::WORD_W-1];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last     <= s_tlast;
      in_range <= (in_range_mm >= range_min_mm) && (in_range_mm <= range_max_mm);
      lhs_base <= range_x1000;
    end
    if (state == S_RD) begin
      latch <= scan_rd.brake;
      angle <= scan_rd.angle;
      cmag  <= cos_rom[rom_idx];
      cneg  <= cos_quad[1] ^ cos_quad[0];
    end
    if (state == S_MUL1) begin
      speed <= ram_rdata[15:0];
      sneg  <= ram_rdata[15];
      prod1 <= 32'(ttc_threshold_ms) * 32'(smag);
    end
    if (state == S_MUL2) begin
      prod2 <= 48'(prod1) * 48'(cmag);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (wb_fire && last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_fire && last) begin
      out_brake <= brake_new;
      out_speed <= brake_new ? 16'd0 : speed;
    end
  end

  assign m_tdata = {7'd0, out_speed, out_brake};

endmodule

`default_nettype wire

// ===== rtl/ttc_eb_checker.sv =====
// ----------------------------------------------------------------------------
// Time-to-collision emergency brake: port checker
// Watches the top-level ports for ordering and result consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module ttc_eb_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata
);

  // A held result must not change while it waits.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Result changed while stalled.");

  // A braking result always commands zero speed.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && (m_tdata[16:1] != 16'd0)))
    else $error("Brake set with nonzero drive speed.");

  // The state memory is written before the first request is taken.
  assert property (@(posedge clk)
    $past(rst) |-> !s_tready)
    else $error("Request taken during the initialization pass.");

  // A beam request occupies the core for the following cycle.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser |=> !s_tready)
    else $error("Request taken while a beam is in progress.");

endmodule

bind ttc_emergency_brake_core ttc_eb_checker u_checker (.*);

`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for the time-to-collision emergency brake core
// Drives speed and beam requests over the input stream, keeps a bit-exact
// prediction of the brake latch, beam angle and cosine lookup, and checks
// every scan result against it. Starts with directed cases, then runs phases
// of random scans under changing register settings and random back-pressure.
// ----------------------------------------------------------------------------

class brake_scoreboard;
  localparam int COS_BITS = 12;
  localparam int QTR = 1 << (COS_BITS - 2);
  localparam bit KIND_SPEED = 1'b0;

  typedef struct packed {
    logic        brake;
    logic [15:0] speed;
  } brake_cmd_t;

  logic [15:0] ttc_ms;
  logic [15:0] rng_min;
  logic [15:0] rng_max;
  logic [15:0] ang_start;
  logic [9:0]  ang_step;
  logic [15:0] speed;
  logic [15:0] angle;
  bit          latch;
  logic [15:0] cos_q15 [QTR+1];
  brake_cmd_t  pending_cmds[$];
  int unsigned n_errors;
  int unsigned n_requests;
  int unsigned n_results;
  int unsigned n_brakes;

  function new();
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned sub;
    int unsigned q;
    int unsigned k;
    int unsigned divs [5];
    divs = '{90, 56, 30, 12, 2};
    for (q = 0; q <= QTR; q++) begin
      x  = (64'd1686629713 * 64'(q)) / 64'(QTR);
      x2 = (x * x) >> 30;
      t  = 64'd1 << 30;
      for (k = 0; k < 5; k++) begin
        sub = (x2 * t) / (64'(divs[k]) << 30);
        t = (sub >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - sub;
      end
      t = (t + (64'd1 << 14)) >> 15;
      cos_q15[q] = (t > 64'd32768) ? 16'h8000 : 16'(t);
    end
    ttc_ms     = 16'd500;
    rng_min    = 16'd0;
    rng_max    = 16'hFFFF;
    ang_start  = 16'hA000;
    ang_step   = 10'd46;
    speed      = 16'd0;
    angle      = 16'hA000;
    latch      = 1'b0;
    n_errors   = 0;
    n_requests = 0;
    n_results  = 0;
    n_brakes   = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [15:0] val);
    case (idx)
      ttc_eb_pkg::REG_TTC_THRESHOLD: ttc_ms = val;
      ttc_eb_pkg::REG_RANGE_MIN:     rng_min = val;
      ttc_eb_pkg::REG_RANGE_MAX:     rng_max = val;
      ttc_eb_pkg::REG_ANGLE_START: begin
        ang_start = val;
        angle = val;
      end
      ttc_eb_pkg::REG_ANGLE_STEP:    ang_step = val[9:0];
      default: ;
    endcase
  endfunction

  function void note_request(bit kind, logic [15:0] spd_in, logic [15:0] rng, bit last);
    int unsigned idx;
    int unsigned quad;
    int unsigned r;
    logic [15:0] cos_mag;
    bit cos_neg;
    bit spd_neg;
    logic [16:0] spd_mag;
    longint unsigned lhs;
    longint unsigned rhs;
    brake_cmd_t cmd;
    n_requests++;
    if (kind == KIND_SPEED) begin
      speed = spd_in;
      return;
    end
    if (!latch && rng >= rng_min && rng <= rng_max) begin
      idx  = int'(angle) >> (16 - COS_BITS);
      quad = (idx >> (COS_BITS - 2)) & 3;
      r    = idx & (QTR - 1);
      case (quad)
        0: begin cos_mag = cos_q15[r];       cos_neg = 1'b0; end
        1: begin cos_mag = cos_q15[QTR - r]; cos_neg = 1'b1; end
        2: begin cos_mag = cos_q15[r];       cos_neg = 1'b1; end
        default: begin cos_mag = cos_q15[QTR - r]; cos_neg = 1'b0; end
      endcase
      spd_neg = speed[15];
      spd_mag = spd_neg ? (17'h10000 - 17'(speed)) : 17'(speed);
      if (spd_mag != 0 && cos_mag != 0 && spd_neg == cos_neg) begin
        lhs = 64'(rng) * 64'd1000 * 64'd32768;
        rhs = 64'(ttc_ms) * 64'(spd_mag) * 64'(cos_mag);
        if (lhs < rhs) latch = 1'b1;
      end
    end
    angle = angle + 16'(ang_step);
    if (!last) return;
    cmd.brake = latch;
    cmd.speed = latch ? 16'd0 : speed;
    pending_cmds.push_back(cmd);
    n_results++;
    if (latch) n_brakes++;
    latch = 1'b0;
    angle = ang_start;
  endfunction

  function void check_result(logic [23:0] word);
    brake_cmd_t want;
    if (pending_cmds.size() == 0) begin
      n_errors++;
      $display("%0t: unexpected result, expected none, got brake %0d speed %0d",
               $time, word[0], $signed(word[16:1]));
      return;
    end
    want = pending_cmds.pop_front();
    if (word[0] !== want.brake) begin
      n_errors++;
      $display("%0t: brake mismatch, expected %0d, got %0d", $time, want.brake, word[0]);
    end
    if (word[16:1] !== want.speed) begin
      n_errors++;
      $display("%0t: drive speed mismatch, expected %0d, got %0d",
               $time, $signed(want.speed), $signed(word[16:1]));
    end
  endfunction
endclass

module tb_top;

  localparam bit KIND_SPEED = 1'b0;
  localparam bit KIND_BEAM  = 1'b1;
  localparam logic [2:0] REG_SPARE_LO = 3'd5;
  localparam int unsigned DRAIN_CYCLES   = 12;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned N_PHASES       = 10;
  localparam int unsigned RANDOM_ITEMS   = 1630;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  brake_scoreboard sb;
  int unsigned n_sent = 0;
  int unsigned idle_cycles = 0;
  int unsigned rx_hold = 0;
  bit          rx_free = 1'b0;
  bit          tx_burst = 1'b0;

  ttc_emergency_brake_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(80, 20);
  endfunction

  function automatic logic [15:0] pick_of(logic [15:0] lo, logic [15:0] hi, logic [15:0] mid);
    int unsigned r;
    r = $urandom_range(5);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return mid;
  endfunction

  function automatic logic [15:0] pick_speed();
    case ($urandom_range(9))
      0: return 16'($urandom);
      1: return pick_of(16'h7FFF, 16'h8000, pick_of(16'h0000, 16'hFFFF, 16'h0001));
      default: return 16'(int'($urandom_range(12000)) - 6000);
    endcase
  endfunction

  // Ranges are drawn partly around the distance at which braking would start.
  function automatic logic [15:0] pick_range();
    longint unsigned reach;
    logic [15:0] mag;
    mag = sb.speed[15] ? 16'(-sb.speed) : sb.speed;
    reach = 2 * (64'(sb.ttc_ms) * 64'(mag)) / 1000 + 16;
    if (reach > 65535) reach = 65535;
    case ($urandom_range(9))
      0, 1, 2: return 16'($urandom);
      3, 4, 5, 6: return 16'($urandom_range(32'(reach)));
      7: begin
        case ($urandom_range(3))
          0: return sb.rng_min;
          1: return sb.rng_min - 16'd1;
          2: return sb.rng_max;
          default: return sb.rng_max + 16'd1;
        endcase
      end
      8: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom_range(2000));
    endcase
  endfunction

  always @(negedge clk) begin
    if (rx_hold != 0) begin
      rx_hold = rx_hold - 1;
      m_tready <= 1'b0;
    end else if (!rx_free && $urandom_range(3) == 0) begin
      rx_hold = pick_gap();
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if (s_tvalid && s_tready) sb.note_request(s_tuser, s_tdata[15:0], s_tdata[31:16], s_tlast);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no request or result moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Called just after a falling edge; returns just after the falling edge
  // that follows acceptance.
  task automatic drive_request(input bit kind, input logic [15:0] spd, input logic [15:0] rng,
                               input bit last);
    int unsigned gap;
    gap = tx_burst ? 0 : pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tlast  <= last;
    s_tdata  <= {rng, spd};
    do @(posedge clk); while (!s_tready);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic send_speed(input logic [15:0] spd, input bit last);
    drive_request(KIND_SPEED, spd, 16'($urandom), last);
  endtask

  task automatic send_beam(input logic [15:0] rng, input bit last);
    drive_request(KIND_BEAM, 16'($urandom), rng, last);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending_cmds.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic poke_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic end_pokes();
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic shuffle_config();
    if ($urandom_range(3) != 0)
      poke_reg(ttc_eb_pkg::REG_TTC_THRESHOLD,
               pick_of(16'd0, 16'hFFFF, 16'($urandom_range(3000, 20))));
    if ($urandom_range(3) != 0)
      poke_reg(ttc_eb_pkg::REG_RANGE_MIN, pick_of(16'd0, 16'hFFFF, 16'($urandom_range(400))));
    if ($urandom_range(3) != 0)
      poke_reg(ttc_eb_pkg::REG_RANGE_MAX,
               pick_of(16'd0, 16'hFFFF, 16'($urandom_range(65535, 1500))));
    if ($urandom_range(3) != 0)
      poke_reg(ttc_eb_pkg::REG_ANGLE_START, pick_of(16'h8000, 16'h7FFF, 16'($urandom)));
    if ($urandom_range(3) != 0)
      poke_reg(ttc_eb_pkg::REG_ANGLE_STEP, pick_of(16'd0, 16'h03FF, 16'($urandom)));
    if ($urandom_range(4) == 0)
      poke_reg(REG_SPARE_LO + 3'($urandom_range(2)), 16'($urandom));
    end_pokes();
  endtask

  task automatic run_scan(input bit finish);
    int unsigned n;
    int unsigned i;
    n = ($urandom_range(9) == 0) ? $urandom_range(64, 17) : $urandom_range(16, 1);
    if ($urandom_range(2) != 0) send_speed(pick_speed(), 1'($urandom));
    for (i = 0; i < n; i++) begin
      if ($urandom_range(11) == 0) send_speed(pick_speed(), 1'($urandom));
      send_beam(pick_range(), finish && i == n - 1);
    end
  endtask

  initial begin
    int unsigned phase;
    int unsigned goal;
    sb = new();
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    send_speed(16'h7FFF, 1'b1);
    send_beam(16'hFFFF, 1'b0);
    send_beam(16'h0000, 1'b1);
    send_speed(16'h8000, 1'b0);
    send_beam(16'h0000, 1'b1);
    send_speed(16'h0000, 1'b0);
    send_beam(16'h0000, 1'b1);

    settle();
    poke_reg(ttc_eb_pkg::REG_TTC_THRESHOLD, 16'hFFFF);
    poke_reg(ttc_eb_pkg::REG_RANGE_MIN, 16'd100);
    poke_reg(ttc_eb_pkg::REG_RANGE_MAX, 16'd200);
    poke_reg(ttc_eb_pkg::REG_ANGLE_START, 16'h0000);
    poke_reg(ttc_eb_pkg::REG_ANGLE_STEP, 16'hFFFF);
    poke_reg(REG_SPARE_LO, 16'hFFFF);
    end_pokes();
    send_speed(16'h7FFF, 1'b0);
    send_beam(16'd99, 1'b0);
    send_beam(16'd201, 1'b0);
    send_beam(16'd100, 1'b1);
    send_beam(16'd150, 1'b0);
    send_beam(16'd200, 1'b0);
    send_beam(16'hFFFF, 1'b1);

    settle();
    poke_reg(ttc_eb_pkg::REG_RANGE_MIN, 16'd300);
    end_pokes();
    send_beam(16'd250, 1'b1);

    settle();
    poke_reg(ttc_eb_pkg::REG_RANGE_MIN, 16'd0);
    poke_reg(ttc_eb_pkg::REG_RANGE_MAX, 16'hFFFF);
    poke_reg(ttc_eb_pkg::REG_ANGLE_START, 16'h4000);
    poke_reg(ttc_eb_pkg::REG_ANGLE_STEP, 16'd0);
    end_pokes();
    send_beam(16'h0000, 1'b1);

    settle();
    poke_reg(ttc_eb_pkg::REG_ANGLE_START, 16'h8000);
    end_pokes();
    send_beam(16'h0000, 1'b1);
    send_speed(16'hFFFF, 1'b0);
    send_beam(16'h0000, 1'b1);

    settle();
    poke_reg(ttc_eb_pkg::REG_TTC_THRESHOLD, 16'd0);
    poke_reg(ttc_eb_pkg::REG_ANGLE_START, 16'h7FFF);
    end_pokes();
    send_beam(16'h0000, 1'b1);
    send_beam(16'd500, 1'b0);

    // An angle start write in the middle of a scan restarts the angle sequence.
    settle();
    poke_reg(ttc_eb_pkg::REG_TTC_THRESHOLD, 16'd500);
    poke_reg(ttc_eb_pkg::REG_ANGLE_START, 16'h0000);
    poke_reg(ttc_eb_pkg::REG_ANGLE_STEP, 16'd46);
    end_pokes();
    send_beam(16'h0000, 1'b1);

    for (phase = 0; phase < N_PHASES; phase++) begin
      settle();
      shuffle_config();
      case ($urandom_range(3))
        0: begin rx_free = 1'b1; tx_burst = 1'b1; end
        1: begin rx_free = 1'b0; tx_burst = 1'b1; end
        2: begin rx_free = 1'b1; tx_burst = 1'b0; end
        default: begin rx_free = 1'b0; tx_burst = 1'b0; end
      endcase
      goal = n_sent + RANDOM_ITEMS / N_PHASES;
      while (n_sent < goal) begin
        run_scan($urandom_range(11) != 0);
        if ($urandom_range(29) == 0) settle();
      end
    end

    s_tvalid <= 1'b0;
    while (sb.pending_cmds.size() != 0) @(negedge clk);
    repeat (2 * DRAIN_CYCLES) @(negedge clk);
    $display("Sent %0d requests in %0d random phases after the directed cases;",
             sb.n_requests, N_PHASES);
    $display("checked %0d scan results, %0d of them braking.", sb.n_results, sb.n_brakes);
    if (sb.n_errors == 0 && sb.pending_cmds.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ttc_eb_pkg.sv
rtl/ttc_eb_ram.sv
rtl/ttc_emergency_brake_core.sv
rtl/ttc_eb_checker.sv
bench/tb_top.sv
